// ===== rtl/bmf_pkg.sv =====
// Package: shared constants and types for the box mean filter.
`default_nettype none
package bmf_pkg;
  localparam int CFG_W     = 11;   // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int CSUM_W    = 11;   // column sum width
  localparam int ROW_W     = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int KREG_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_KERNEL_HEIGHT = 2'd2,
    REG_KERNEL_WIDTH  = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/bmf_pixel_if.sv =====
// Interface: input pixel channel.
`default_nettype none
interface bmf_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmf_result_if.sv =====
// Interface: output mean channel.
`default_nettype none
interface bmf_result_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  mean_value;
  logic                       frame_end;
  modport source (output valid, output mean_value, output frame_end, input ready);
  modport sink   (input valid, input mean_value, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmf_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/box_mean_filter_2d.sv =====
// Top level: streaming 2-D box mean filter over the valid region of a frame.
// Flow: accept, line store read/update, window summing over kernel_width
// column sums, then bit-serial division.
// Throughput: a new pixel is accepted only once the previous one has passed
// the line store update and, when a result is due, the divider; the last
// division step also waits while the previous result has not been taken.
// Reset: synchronous; registers to 1024/1024/3/3, positions and column sums
// to zero; the line store RAM is not cleared.
`default_nettype none
module box_mean_filter_2d #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bmf_pkg::CFG_W-1:0]       cfg_data,
  bmf_pixel_if.sink                            pix,
  bmf_result_if.source                         res
);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WE_W   = $clog2(MAX_WIDTH + 1);
  localparam int KE_W   = $clog2(MAX_KERNEL + 1);
  localparam int KI_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int ROWS   = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LS_W   = ROWS * bmf_pkg::PIX_W;
  localparam int TW     = bmf_pkg::CSUM_W + $clog2(MAX_KERNEL + 1);
  localparam int AW     = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int CNT_W  = $clog2(TW + MAX_KERNEL);

  // configuration registers
  logic [bmf_pkg::CFG_W-1:0]  image_width, image_height;
  logic [bmf_pkg::KREG_W-1:0] kernel_height, kernel_width;

  // effective (clamped) values
  logic [WE_W-1:0]            w_eff;
  logic [bmf_pkg::CFG_W-1:0]  h_eff;
  logic [KE_W-1:0]            kh_eff, kw_eff;

  always_comb begin
    if (image_width == '0) w_eff = WE_W'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = WE_W'(MAX_WIDTH);
    else w_eff = WE_W'(image_width);
    if (image_height == '0) h_eff = bmf_pkg::CFG_W'(1);
    else if (32'(image_height) > bmf_pkg::MAX_HEIGHT)
      h_eff = bmf_pkg::CFG_W'(bmf_pkg::MAX_HEIGHT);
    else h_eff = image_height;
    if (kernel_height == '0) kh_eff = KE_W'(1);
    else if (32'(kernel_height) > MAX_KERNEL) kh_eff = KE_W'(MAX_KERNEL);
    else kh_eff = KE_W'(kernel_height);
    if (kernel_width == '0) kw_eff = KE_W'(1);
    else if (32'(kernel_width) > MAX_KERNEL) kw_eff = KE_W'(MAX_KERNEL);
    else kw_eff = KE_W'(kernel_width);
  end

  // control and datapath registers
  bmf_pkg::state_t              state;
  logic [COL_W-1:0]             col;
  logic [bmf_pkg::ROW_W-1:0]    row;
  logic [bmf_pkg::PIX_W-1:0]    px;
  logic [bmf_pkg::CSUM_W-1:0]   wsum [MAX_KERNEL];
  logic [CNT_W-1:0]             cnt;
  logic [TW-1:0]                acc;
  logic [AW-1:0]                area;
  logic [AW-1:0]                rem;
  logic [bmf_pkg::PIX_W-1:0]    quo;
  logic                         fe_pend;

  // line store RAM: one word per column holds all stored rows
  logic             mem_we;
  logic [LS_W-1:0]  mem_rdata, mem_wdata;

  bmf_ram #(.WIDTH(LS_W), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (col),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // column sum and shifted line store word
  logic [bmf_pkg::CSUM_W-1:0] col_sum;
  always_comb begin
    col_sum = bmf_pkg::CSUM_W'(px);
    for (int k = 0; k < ROWS; k++) begin
      if (k + 1 < 32'(kh_eff))
        col_sum = col_sum + bmf_pkg::CSUM_W'(mem_rdata[k*bmf_pkg::PIX_W +: bmf_pkg::PIX_W]);
    end
    mem_wdata = mem_rdata;
    mem_wdata[bmf_pkg::PIX_W-1:0] = px;
    for (int k = 1; k < ROWS; k++) begin
      if (k + 2 <= 32'(kh_eff))
        mem_wdata[k*bmf_pkg::PIX_W +: bmf_pkg::PIX_W] =
          mem_rdata[(k-1)*bmf_pkg::PIX_W +: bmf_pkg::PIX_W];
    end
  end

  assign mem_we = (state == bmf_pkg::ST_RD);

  // window and position tests
  logic col_last, row_last, emit;
  assign col_last = (32'(col) == 32'(w_eff) - 1);
  assign row_last = (32'(row) == 32'(h_eff) - 1);
  assign emit = (32'(kh_eff) <= 32'(h_eff)) && (32'(kw_eff) <= 32'(w_eff)) &&
                (32'(row) + 1 >= 32'(kh_eff)) && (32'(col) + 1 >= 32'(kw_eff));

  // divider step
  logic [AW:0] trial;
  logic        div_last, div_go, res_load;
  assign trial    = {rem, acc[TW-1]};
  assign div_last = (cnt == CNT_W'(TW - 1));
  assign div_go   = !div_last || !res.valid || res.ready;
  assign res_load = (state == bmf_pkg::ST_DIV) && div_go && div_last;

  assign pix.ready = (state == bmf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bmf_pkg::ST_IDLE;
      image_width   <= bmf_pkg::CFG_W'(1024);
      image_height  <= bmf_pkg::CFG_W'(1024);
      kernel_height <= bmf_pkg::KREG_W'(3);
      kernel_width  <= bmf_pkg::KREG_W'(3);
      col           <= '0;
      row           <= '0;
      res.valid     <= 1'b0;
      cnt           <= '0;
      for (int k = 0; k < MAX_KERNEL; k++) wsum[k] <= '0;
    end else begin
      // output register: load when the divider finishes, else drain on accept
      if (res_load) res.valid <= 1'b1;
      else if (res.valid && res.ready) res.valid <= 1'b0;

      if (cfg_we) begin
        unique case (bmf_pkg::reg_index_t'(cfg_index))
          bmf_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          bmf_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          bmf_pkg::REG_KERNEL_HEIGHT: kernel_height <= cfg_data[bmf_pkg::KREG_W-1:0];
          bmf_pkg::REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[bmf_pkg::KREG_W-1:0];
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end

      unique case (state)
        bmf_pkg::ST_IDLE: begin
          if (pix.valid) begin
            px    <= pix.pixel;
            state <= bmf_pkg::ST_RD;
          end
        end
        bmf_pkg::ST_RD: begin
          for (int k = MAX_KERNEL - 1; k > 0; k--) wsum[k] <= wsum[k-1];
          wsum[0] <= col_sum;
          fe_pend <= row_last && col_last;
          area    <= AW'(kh_eff) * AW'(kw_eff);
          acc     <= '0;
          cnt     <= '0;
          // advance raster position
          if (col_last) begin
            col <= '0;
            row <= row_last ? '0 : row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          state <= emit ? bmf_pkg::ST_SUM : bmf_pkg::ST_IDLE;
        end
        bmf_pkg::ST_SUM: begin
          acc <= acc + TW'(wsum[cnt[KI_W-1:0]]);
          if (32'(cnt) + 1 == 32'(kw_eff)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= bmf_pkg::ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        bmf_pkg::ST_DIV: begin
          if (div_go) begin
            acc <= {acc[TW-2:0], 1'b0};
            if (trial >= {1'b0, area}) begin
              rem <= AW'(trial - {1'b0, area});
              quo <= {quo[bmf_pkg::PIX_W-2:0], 1'b1};
            end else begin
              rem <= trial[AW-1:0];
              quo <= {quo[bmf_pkg::PIX_W-2:0], 1'b0};
            end
            if (div_last) begin
              res.mean_value <= {quo[bmf_pkg::PIX_W-2:0], (trial >= {1'b0, area})};
              res.frame_end  <= fe_pend;
              state          <= bmf_pkg::ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= bmf_pkg::ST_IDLE;
      endcase
    end
  end

  // checks
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == bmf_pkg::ST_RD))
    else $error("accepted pixel did not start a line store update");
  a_result_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == bmf_pkg::ST_DIV))
    else $error("result loaded outside the divider");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready && state == bmf_pkg::ST_DIV) |=> (state == bmf_pkg::ST_DIV))
    else $error("divider finished over a pending result");
endmodule
`default_nettype wire
